/* hdl/eemi_pkg.sv */
package eemi_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [WIDTH-1:0] divisor;
    logic [WIDTH-1:0] inverse;
  } rsp_t;

  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] acc;
  } step_res_t;

endpackage

/* hdl/eemi_step.sv */
module eemi_step (
  input  logic [eemi_pkg::WIDTH-1:0] rem,
  input  logic                       dvd_bit,
  input  logic [eemi_pkg::WIDTH-1:0] dvs,
  input  logic [eemi_pkg::WIDTH-1:0] acc,
  input  logic [eemi_pkg::WIDTH-1:0] mul,
  output eemi_pkg::step_res_t        res
);

  logic [eemi_pkg::WIDTH:0] shifted;
  logic [eemi_pkg::WIDTH:0] diff;
  logic                     ge;

  assign shifted = {rem, dvd_bit};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  // restoring divide bit plus Horner accumulate of quotient times mul
  always_comb begin
    res.rem  = ge ? diff[eemi_pkg::WIDTH-1:0] : shifted[eemi_pkg::WIDTH-1:0];
    res.acc  = {acc[eemi_pkg::WIDTH-2:0], 1'b0} + (ge ? mul : {eemi_pkg::WIDTH{1'b0}});
  end

endmodule

/* hdl/extended_euclid_mod_inverse.sv */
// Extended Euclidean modular inverse.
// Input channel (in_valid/in_ready/in_data) takes one request holding a
// modulus and an operand. Result channel (out_valid/out_ready/out_data)
// returns the gcd and the Bezout coefficient of the operand, made
// non-negative by adding the modulus; it is the inverse when gcd is 1.
// The block handles one request at a time: in_ready is high only while
// the sequencer is idle. Each Euclid step runs a bit-serial restoring
// divider that also accumulates quotient times coefficient, plus one
// test and one update state. out_valid rises in the same cycle as
// in_ready, when the sequencer returns to idle after the last step;
// for 32-bit values at most about 47 Euclid steps are needed.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, a finished result holds in the
// sequencer until the output register frees up.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// any pending result.
module extended_euclid_mod_inverse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  eemi_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output eemi_pkg::rsp_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TEST = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  localparam int W = eemi_pkg::WIDTH;

  logic [1:0]                 state_r, state_nxt;
  logic                       done_r, done_nxt;
  logic [W-1:0]               ra_r, ra_nxt;
  logic [W-1:0]               rb_r, rb_nxt;
  logic [W-1:0]               ma_r, ma_nxt;
  logic [W-1:0]               mb_r, mb_nxt;
  logic [W-1:0]               rem_r, rem_nxt;
  logic [W-1:0]               acc_r, acc_nxt;
  logic [W-1:0]               mod_r, mod_nxt;
  logic                       par_r, par_nxt;
  logic [eemi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  eemi_pkg::rsp_t             out_data_r, out_data_nxt;
  eemi_pkg::step_res_t        step_res;
  logic [W-1:0]               inv_val;

  eemi_step u_step (
    .rem     (rem_r),
    .dvd_bit (ra_r[W-1]),
    .dvs     (rb_r),
    .acc     (acc_r),
    .mul     (mb_r),
    .res     (step_res)
  );

  assign inv_val = ((ma_r != {W{1'b0}}) && !par_r) ? (mod_r - ma_r) : ma_r;

  always_comb begin
    state_nxt     = state_r;
    done_nxt      = done_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    mod_nxt       = mod_r;
    par_nxt       = par_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ra_nxt    = in_data.modulus;
          rb_nxt    = in_data.operand;
          ma_nxt    = {W{1'b0}};
          mb_nxt    = W'(1);
          par_nxt   = 1'b0;
          mod_nxt   = in_data.modulus;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (done_r) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.divisor = ra_r;
            out_data_nxt.inverse = inv_val;
            done_nxt             = 1'b0;
            state_nxt            = ST_IDLE;
          end
        end else if (rb_r == {W{1'b0}}) begin
          done_nxt = 1'b1;
        end else begin
          rem_nxt   = {W{1'b0}};
          acc_nxt   = {W{1'b0}};
          cnt_nxt   = eemi_pkg::CNT_W'(W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = step_res.rem;
        acc_nxt = step_res.acc;
        ra_nxt  = {ra_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - eemi_pkg::CNT_W'(1);
        if (cnt_r == {eemi_pkg::CNT_W{1'b0}}) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ra_nxt    = rb_r;
        rb_nxt    = rem_r;
        ma_nxt    = mb_r;
        mb_nxt    = ma_r + acc_r;
        par_nxt   = ~par_r;
        state_nxt = ST_TEST;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    mod_r      <= mod_nxt;
    par_r      <= par_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE) && !done_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/eemi_check.sv */
module eemi_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input eemi_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_ready,
  input eemi_pkg::rsp_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

  // zero operand: gcd is the modulus, coefficient zero
  a_zero_operand: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operand == '0) && (!out_valid || out_ready)
    |-> ##3 out_valid && (out_data.divisor == $past(in_data.modulus, 3))
        && (out_data.inverse == '0))
    else $error("zero operand result wrong");

endmodule

bind extended_euclid_mod_inverse eemi_check u_eemi_check (.*);
